// File: hdl/plr_pkg.sv
package plr_pkg;

  localparam int MAX_BREAKPOINTS = 256;
  localparam int ADDR_W = $clog2(MAX_BREAKPOINTS);
  localparam int CNT_W  = $clog2(MAX_BREAKPOINTS + 1);

  localparam int X_W  = 24;
  localparam int Y_W  = 32;
  localparam int GP_W = 16;
  localparam int XQ_W = GP_W + X_W;

  // shared divider: dividend holds the query value or |dy|*dx, divisor holds a span of x
  localparam int DIV_NW = Y_W + X_W;
  localparam int DIV_DW = X_W;

  localparam int CFG_AW = 4;

  localparam logic [1:0] REG_RATE_MODE     = 2'd0;
  localparam logic [1:0] REG_CONST_RATE    = 2'd1;
  localparam logic [1:0] REG_GRID_INTERVAL = 2'd2;
  localparam logic [1:0] REG_GRID_POINTS   = 2'd3;

  localparam logic [X_W-1:0]  GRID_INTERVAL_RST = X_W'(131);
  localparam logic [GP_W-1:0] GRID_POINTS_RST   = GP_W'(10001);

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  localparam logic MODE_TABLE = 1'b0;
  localparam logic MODE_CONST = 1'b1;

  localparam logic [1:0] ST_QUERY_OK  = 2'd0;
  localparam logic [1:0] ST_NO_BREAKS = 2'd1;
  localparam logic [1:0] ST_LOAD_FULL = 2'd2;
  localparam logic [1:0] ST_LOAD_OK   = 2'd3;

  typedef struct packed {
    logic              done;
    logic [DIV_NW-1:0] quo;
  } div_res_t;

endpackage

// File: hdl/plr_divider.sv
module plr_divider import plr_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DIV_NW-1:0] dividend,
  input  logic [DIV_DW-1:0] divisor,
  output div_res_t          res
);

  localparam int SW = $clog2(DIV_NW);
  localparam logic [SW-1:0] STEP_LAST = SW'(DIV_NW - 1);

  logic              busy_r;
  logic              done_r;
  logic [SW-1:0]     step_r;
  logic [DIV_NW-1:0] quo_r;
  logic [DIV_DW-1:0] rem_r;
  logic [DIV_DW-1:0] dvs_r;

  logic [DIV_DW:0] rem_sh;
  logic [DIV_DW:0] rem_sub;
  logic            fits;

  // restoring division, one quotient bit a cycle
  assign rem_sh  = {rem_r, quo_r[DIV_NW-1]};
  assign fits    = rem_sh >= {1'b0, dvs_r};
  assign rem_sub = rem_sh - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + SW'(1);
        if (step_r == STEP_LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[DIV_NW-2:0], fits};
      rem_r <= fits ? rem_sub[DIV_DW-1:0] : rem_sh[DIV_DW-1:0];
    end
  end

  assign res.done = done_r;
  assign res.quo  = quo_r;

endmodule

// File: hdl/plr_table.sv
module plr_table import plr_pkg::*; (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [X_W-1:0]    wr_x,
  input  logic [Y_W-1:0]    wr_y,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [X_W-1:0]    rd_x,
  output logic [Y_W-1:0]    rd_y
);

  logic [X_W-1:0] x_mem [MAX_BREAKPOINTS];
  logic [Y_W-1:0] y_mem [MAX_BREAKPOINTS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      x_mem[wr_addr] <= wr_x;
      y_mem[wr_addr] <= wr_y;
    end
  end

  // registered read, one entry a cycle
  always_ff @(posedge clk) begin
    rd_x <= x_mem[rd_addr];
    rd_y <= y_mem[rd_addr];
  end

endmodule

// File: hdl/piecewise_linear_rate_lookup.sv
// piecewise-linear rate lookup: loads append (x, y) breakpoints (x in Q8.16, y
// on a software-chosen 32-bit scale; the user must keep ascending x order, the
// block does not enforce it) until the table of MAX_BREAKPOINTS entries is
// full; a query snaps its value down to the grid index floor(v/grid_interval)
// (clamped to grid_points-1) times grid_interval and returns y interpolated on
// the enclosing segment, truncated toward y0, or the first/last y outside the
// table range. every item gives exactly one result transfer. a load, a
// constant-mode query and a query on an empty table are answered from the idle
// state. a table query uses up to two passes of the shared 56-step serial
// divider (grid index, then slope) and a scan that reads one table entry per
// cycle from the breakpoint memory. the input side stalls while a query is in
// progress and while a finished result is still held by a stalled output.
// configuration is an apb-style port, four registers in 32-bit words at byte
// offsets 0, 4, 8 and 12: rate_mode, const_rate, grid_interval, grid_points.
module piecewise_linear_rate_lookup import plr_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  // input channel
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_req_type,
  input  logic [X_W-1:0]    in_bp_x,
  input  logic [Y_W-1:0]    in_bp_y,
  input  logic [X_W-1:0]    in_query_value,
  // result channel
  output logic              out_valid,
  input  logic              out_stall,
  output logic [Y_W-1:0]    out_rate,
  output logic [1:0]        out_status,
  output logic              out_index_clamped,
  // configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV_G,
    S_GRID,
    S_SCAN,
    S_DECIDE,
    S_PROD,
    S_DIV_GO,
    S_DIV_M,
    S_FINISH
  } state_t;

  state_t state_r;

  // configuration registers
  logic            rate_mode_r;
  logic [Y_W-1:0]  const_rate_r;
  logic [X_W-1:0]  grid_interval_r;
  logic [GP_W-1:0] grid_points_r;

  logic [CNT_W-1:0] break_count_r;

  // query datapath
  logic [GP_W-1:0]  g_r;
  logic             clamp_r;
  logic [XQ_W-1:0]  xq_r;
  logic [CNT_W-1:0] issue_idx_r;
  logic             proc_v_r;
  logic [CNT_W-1:0] proc_idx_r;
  logic [X_W-1:0]   first_x_r;
  logic [Y_W-1:0]   first_y_r;
  logic [X_W-1:0]   prev_x_r;
  logic [Y_W-1:0]   prev_y_r;
  logic [X_W-1:0]   s_x0_r;
  logic [Y_W-1:0]   s_y0_r;
  logic [X_W-1:0]   s_x1_r;
  logic [Y_W-1:0]   s_y1_r;
  logic [X_W-1:0]   dx_r;
  logic [X_W-1:0]   den_r;
  logic [Y_W-1:0]   ady_r;
  logic             neg_r;
  logic [DIV_NW-1:0] prod_r;
  logic [Y_W-1:0]   rate_r;

  // output register
  logic            out_valid_r;
  logic [Y_W-1:0]  out_rate_r;
  logic [1:0]      out_status_r;
  logic            out_clamped_r;

  logic              accept_in;
  logic              out_free;
  logic              cfg_wr;
  logic [1:0]        cfg_idx;
  logic [GP_W-1:0]   gp_limit;
  logic              table_full;
  logic              tbl_wr;
  logic              div_start;
  logic [DIV_NW-1:0] div_dividend;
  logic [DIV_DW-1:0] div_divisor;
  div_res_t          div_res;
  logic [X_W-1:0]    g_full;
  logic              g_over;
  logic              issuing;
  logic [CNT_W-1:0]  cnt_last;
  logic [X_W-1:0]    rd_x;
  logic [Y_W-1:0]    rd_y;
  logic [XQ_W-1:0]   rd_x_ext;
  logic [XQ_W-1:0]   prev_x_ext;
  logic [XQ_W-1:0]   first_x_ext;

  // handshakes
  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE) || !out_free;
  assign accept_in = in_valid && !in_stall;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[CFG_AW-1:2];

  always_comb begin
    case (cfg_idx)
      REG_RATE_MODE:     prdata = {31'b0, rate_mode_r};
      REG_CONST_RATE:    prdata = const_rate_r;
      REG_GRID_INTERVAL: prdata = {{(32-X_W){1'b0}}, grid_interval_r};
      REG_GRID_POINTS:   prdata = {{(32-GP_W){1'b0}}, grid_points_r};
      default:           prdata = '0;
    endcase
  end

  // highest grid index; zero grid points also limits to zero
  assign gp_limit   = (grid_points_r == '0) ? '0 : grid_points_r - GP_W'(1);
  assign table_full = break_count_r == CNT_W'(MAX_BREAKPOINTS);
  assign tbl_wr     = accept_in && (in_req_type == REQ_LOAD) && !table_full;
  assign cnt_last   = break_count_r - CNT_W'(1);

  // the divider serves the grid index first, then the slope term
  assign div_start = (accept_in && (in_req_type == REQ_QUERY) &&
                      (rate_mode_r == MODE_TABLE) && (break_count_r != '0) &&
                      (grid_interval_r != '0)) ||
                     (state_r == S_DIV_GO);
  assign div_dividend = (state_r == S_IDLE) ?
                        {{(DIV_NW-X_W){1'b0}}, in_query_value} : prod_r;
  assign div_divisor  = (state_r == S_IDLE) ? grid_interval_r : den_r;

  assign g_full = div_res.quo[X_W-1:0];
  assign g_over = g_full > {{(X_W-GP_W){1'b0}}, gp_limit};

  // scan issues one read per cycle; data comes back in the next cycle
  assign issuing     = issue_idx_r < break_count_r;
  assign rd_x_ext    = {{GP_W{1'b0}}, rd_x};
  assign prev_x_ext  = {{GP_W{1'b0}}, prev_x_r};
  assign first_x_ext = {{GP_W{1'b0}}, first_x_r};

  plr_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .res      (div_res)
  );

  plr_table u_tbl (
    .clk     (clk),
    .wr_en   (tbl_wr),
    .wr_addr (break_count_r[ADDR_W-1:0]),
    .wr_x    (in_bp_x),
    .wr_y    (in_bp_y),
    .rd_addr (issue_idx_r[ADDR_W-1:0]),
    .rd_x    (rd_x),
    .rd_y    (rd_y)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      rate_mode_r     <= MODE_TABLE;
      const_rate_r    <= '0;
      grid_interval_r <= GRID_INTERVAL_RST;
      grid_points_r   <= GRID_POINTS_RST;
      break_count_r   <= '0;
      out_valid_r     <= 1'b0;
      proc_v_r        <= 1'b0;
    end else begin
      if (cfg_wr) begin
        unique case (cfg_idx)
          REG_RATE_MODE:     rate_mode_r     <= pwdata[0];
          REG_CONST_RATE:    const_rate_r    <= pwdata;
          REG_GRID_INTERVAL: grid_interval_r <= pwdata[X_W-1:0];
          REG_GRID_POINTS:   grid_points_r   <= pwdata[GP_W-1:0];
          default: ;
        endcase
      end

      // result transfer frees the output register
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (accept_in) begin
            if (in_req_type == REQ_LOAD) begin
              out_valid_r   <= 1'b1;
              out_rate_r    <= '0;
              out_clamped_r <= 1'b0;
              if (table_full) begin
                out_status_r <= ST_LOAD_FULL;
              end else begin
                out_status_r  <= ST_LOAD_OK;
                break_count_r <= break_count_r + CNT_W'(1);
              end
            end else if (rate_mode_r == MODE_CONST) begin
              out_valid_r   <= 1'b1;
              out_rate_r    <= const_rate_r;
              out_status_r  <= ST_QUERY_OK;
              out_clamped_r <= 1'b0;
            end else if (break_count_r == '0) begin
              out_valid_r   <= 1'b1;
              out_rate_r    <= '0;
              out_status_r  <= ST_NO_BREAKS;
              out_clamped_r <= 1'b0;
            end else if (grid_interval_r == '0) begin
              // zero spacing saturates the index
              g_r     <= gp_limit;
              clamp_r <= 1'b1;
              state_r <= S_GRID;
            end else begin
              state_r <= S_DIV_G;
            end
          end
        end

        S_DIV_G: begin
          if (div_res.done) begin
            g_r     <= g_over ? gp_limit : g_full[GP_W-1:0];
            clamp_r <= g_over;
            state_r <= S_GRID;
          end
        end

        S_GRID: begin
          xq_r        <= g_r * grid_interval_r;
          issue_idx_r <= '0;
          proc_v_r    <= 1'b0;
          state_r     <= S_SCAN;
        end

        S_SCAN: begin
          if (issuing) begin
            issue_idx_r <= issue_idx_r + CNT_W'(1);
          end
          proc_v_r   <= issuing;
          proc_idx_r <= issue_idx_r;
          if (proc_v_r) begin
            if (proc_idx_r == '0) begin
              first_x_r <= rd_x;
              first_y_r <= rd_y;
            end else if ((prev_x_ext <= xq_r) && (xq_r < rd_x_ext)) begin
              // latest segment that encloses the grid point wins
              s_x0_r <= prev_x_r;
              s_y0_r <= prev_y_r;
              s_x1_r <= rd_x;
              s_y1_r <= rd_y;
            end
            prev_x_r <= rd_x;
            prev_y_r <= rd_y;
            if (proc_idx_r == cnt_last) begin
              proc_v_r <= 1'b0;
              state_r  <= S_DECIDE;
            end
          end
        end

        S_DECIDE: begin
          if (xq_r <= first_x_ext) begin
            rate_r  <= first_y_r;
            state_r <= S_FINISH;
          end else if (xq_r >= prev_x_ext) begin
            // at or past the last breakpoint
            rate_r  <= prev_y_r;
            state_r <= S_FINISH;
          end else begin
            // grid point lies below s_x1, so it fits in x width
            dx_r    <= xq_r[X_W-1:0] - s_x0_r;
            den_r   <= s_x1_r - s_x0_r;
            neg_r   <= s_y1_r < s_y0_r;
            ady_r   <= (s_y1_r < s_y0_r) ? (s_y0_r - s_y1_r) : (s_y1_r - s_y0_r);
            state_r <= S_PROD;
          end
        end

        S_PROD: begin
          prod_r  <= ady_r * dx_r;
          state_r <= S_DIV_GO;
        end

        S_DIV_GO: begin
          state_r <= S_DIV_M;
        end

        S_DIV_M: begin
          if (div_res.done) begin
            // quotient stays below |dy|, so the low word is exact
            rate_r  <= neg_r ? (s_y0_r - div_res.quo[Y_W-1:0])
                             : (s_y0_r + div_res.quo[Y_W-1:0]);
            state_r <= S_FINISH;
          end
        end

        S_FINISH: begin
          if (out_free) begin
            out_valid_r   <= 1'b1;
            out_rate_r    <= rate_r;
            out_status_r  <= ST_QUERY_OK;
            out_clamped_r <= clamp_r;
            state_r       <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_rate          = out_rate_r;
  assign out_status        = out_status_r;
  assign out_index_clamped = out_clamped_r;

endmodule

// File: hdl/plr_checker.sv
module plr_checker import plr_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic [Y_W-1:0]    out_rate,
  input logic [1:0]        out_status,
  input logic              out_index_clamped
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=>
      out_valid && $stable(out_rate) && $stable(out_status) &&
      $stable(out_index_clamped))
    else $error("stalled result changed");

  // a held result blocks new input
  a_in_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && out_valid && out_stall |-> in_stall)
    else $error("input taken while a result is held");

  // load results carry no rate and no clamp flag
  a_load_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ((out_status == ST_LOAD_OK) || (out_status == ST_LOAD_FULL)) |->
      (out_rate == '0) && !out_index_clamped)
    else $error("load result with nonzero rate or clamp");

  // empty table error carries no rate and no clamp flag
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_NO_BREAKS) |->
      (out_rate == '0) && !out_index_clamped)
    else $error("no-breakpoint result with nonzero rate or clamp");

  // reset leaves no result pending
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind piecewise_linear_rate_lookup plr_checker u_plr_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_rate          (out_rate),
  .out_status        (out_status),
  .out_index_clamped (out_index_clamped)
);

// File: tb/sv/tb_piecewise_linear_rate_lookup.sv
module tb_piecewise_linear_rate_lookup;
  timeunit 1ns;
  timeprecision 1ps;

  import plr_pkg::*;

  // cycles with no transfer on either channel before the run is abandoned;
  // the limit leaves room for a full-table query plus random gaps and stalls
  localparam int IDLE_LIMIT  = 20000;
  localparam int BATCHES     = 4;
  localparam int BATCH_ITEMS = 44;

  typedef struct packed {
    logic [Y_W-1:0] rate;
    logic [1:0]     status;
    logic           index_clamped;
  } rate_result_t;

  typedef struct packed {
    logic           req;
    logic [X_W-1:0] bx;
    logic [Y_W-1:0] by;
    logic [X_W-1:0] qv;
  } lookup_req_t;

  // one row of the directed table: a register write or an item, the latter
  // with an optional hand-written expectation
  typedef struct {
    bit           is_cfg;
    logic [1:0]   reg_sel;
    logic [31:0]  reg_value;
    lookup_req_t  item;
    bit           typed;
    rate_result_t typed_result;
  } directed_row_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              in_req_type = REQ_LOAD;
  logic [X_W-1:0]    in_bp_x = '0;
  logic [Y_W-1:0]    in_bp_y = '0;
  logic [X_W-1:0]    in_query_value = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [Y_W-1:0]    out_rate;
  logic [1:0]        out_status;
  logic              out_index_clamped;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  // shadow copy of the block: registers and breakpoint table
  logic              mode_reg = MODE_TABLE;
  logic [31:0]       const_reg = '0;
  logic [X_W-1:0]    interval_reg = GRID_INTERVAL_RST;
  logic [GP_W-1:0]   points_reg = GRID_POINTS_RST;
  logic [X_W-1:0]    bp_x_mem [MAX_BREAKPOINTS];
  logic [Y_W-1:0]    bp_y_mem [MAX_BREAKPOINTS];
  int unsigned       bp_count = 0;

  rate_result_t      expected_rates[$];
  rate_result_t      head_rate;
  directed_row_t     directed_rows[$];
  int                errors = 0;
  int                idle_cycles = 0;
  int                send_idle_pct = 0;
  int                stall_pct = 0;

  piecewise_linear_rate_lookup dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_req_type       (in_req_type),
    .in_bp_x           (in_bp_x),
    .in_bp_y           (in_bp_y),
    .in_query_value    (in_query_value),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_rate          (out_rate),
    .out_status        (out_status),
    .out_index_clamped (out_index_clamped),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  always #2 clk = ~clk;

  // y at abscissa x: first y below the table, last y at or past its end,
  // otherwise interpolated on the last segment holding x, truncated toward y0
  function automatic logic [Y_W-1:0] interp_table(input logic [63:0] x);
    int unsigned    seg;
    logic [63:0]    dx;
    logic [63:0]    den;
    logic [63:0]    mag;
    logic [Y_W-1:0] y0;
    logic [Y_W-1:0] y1;
    seg = 0;
    if (x <= 64'(bp_x_mem[0])) return bp_y_mem[0];
    if (x >= 64'(bp_x_mem[bp_count-1])) return bp_y_mem[bp_count-1];
    for (int j = 0; j + 1 < bp_count; j++) begin
      if (x >= 64'(bp_x_mem[j]) && x < 64'(bp_x_mem[j+1])) seg = j;
    end
    y0  = bp_y_mem[seg];
    y1  = bp_y_mem[seg+1];
    dx  = x - 64'(bp_x_mem[seg]);
    den = 64'(bp_x_mem[seg+1]) - 64'(bp_x_mem[seg]);
    if (den == 0) return y0;
    if (y1 >= y0) begin
      mag = (64'(y1 - y0) * dx) / den;
      return y0 + mag[Y_W-1:0];
    end
    mag = (64'(y0 - y1) * dx) / den;
    return y0 - mag[Y_W-1:0];
  endfunction

  // result of one accepted item; loads update the shadow table
  function automatic rate_result_t compute_rate_result(input lookup_req_t it);
    rate_result_t    r;
    logic [GP_W-1:0] limit;
    logic [63:0]     g;
    r = '0;
    if (it.req == REQ_LOAD) begin
      if (bp_count < MAX_BREAKPOINTS) begin
        bp_x_mem[bp_count] = it.bx;
        bp_y_mem[bp_count] = it.by;
        bp_count++;
        r.status = ST_LOAD_OK;
      end else begin
        r.status = ST_LOAD_FULL;
      end
      return r;
    end
    r.status = ST_QUERY_OK;
    if (mode_reg == MODE_CONST) begin
      r.rate = const_reg;
      return r;
    end
    if (bp_count == 0) begin
      r.status = ST_NO_BREAKS;
      return r;
    end
    limit = (points_reg > 0) ? points_reg - 1'b1 : '0;
    if (interval_reg == 0) begin
      g = 64'(limit);
      r.index_clamped = 1'b1;
    end else begin
      g = 64'(it.qv / interval_reg);
      if (g > 64'(limit)) begin
        g = 64'(limit);
        r.index_clamped = 1'b1;
      end
    end
    r.rate = interp_table(g * 64'(interval_reg));
    return r;
  endfunction

  task automatic add_cfg(input logic [1:0] sel, input logic [31:0] value);
    directed_row_t r;
    r = '{default: '0};
    r.is_cfg    = 1'b1;
    r.reg_sel   = sel;
    r.reg_value = value;
    directed_rows = {directed_rows, r};
  endtask

  task automatic add_item(input logic req, input logic [X_W-1:0] bx,
                          input logic [Y_W-1:0] by, input logic [X_W-1:0] qv,
                          input bit typed, input logic [Y_W-1:0] rate,
                          input logic [1:0] status, input logic clamped);
    directed_row_t r;
    r = '{default: '0};
    r.item         = '{req, bx, by, qv};
    r.typed        = typed;
    r.typed_result = '{rate, status, clamped};
    directed_rows = {directed_rows, r};
  endtask

  // one apb write: setup phase, access phase until pready, then the bus goes idle
  task automatic write_reg(input logic [1:0] sel, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_AW'({sel, 2'b00});
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (sel)
      REG_RATE_MODE:     mode_reg = value[0];
      REG_CONST_RATE:    const_reg = value;
      REG_GRID_INTERVAL: interval_reg = value[X_W-1:0];
      REG_GRID_POINTS:   points_reg = value[GP_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // every item gives a result, so an empty queue means the block is idle
  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_rates.size() != 0) @(posedge clk);
  endtask

  // offer one item, wait for its transfer, then queue what it should return
  task automatic send_item(input lookup_req_t it, input bit typed,
                           input rate_result_t typed_result);
    rate_result_t predicted;
    if (send_idle_pct != 0) begin
      while ($urandom_range(99) < send_idle_pct) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid       <= 1'b1;
    in_req_type    <= it.req;
    in_bp_x        <= it.bx;
    in_bp_y        <= it.by;
    in_query_value <= it.qv;
    do @(posedge clk); while (in_stall);
    predicted = compute_rate_result(it);
    expected_rates = {expected_rates, (typed ? typed_result : predicted)};
  endtask

  // result side: stall at random, check each transfer, watch for a hang
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end else begin
        if (out_valid && !out_stall) begin
          if (expected_rates.size() == 0) begin
            $error("result with nothing pending: rate %h status %0d clamped %0b",
                   out_rate, out_status, out_index_clamped);
            errors++;
          end else begin
            head_rate = expected_rates.pop_front();
            if (out_rate !== head_rate.rate) begin
              $error("rate: expected %h, got %h", head_rate.rate, out_rate);
              errors++;
            end
            if (out_status !== head_rate.status) begin
              $error("status: expected %0d, got %0d", head_rate.status, out_status);
              errors++;
            end
            if (out_index_clamped !== head_rate.index_clamped) begin
              $error("index_clamped: expected %0b, got %0b",
                     head_rate.index_clamped, out_index_clamped);
              errors++;
            end
          end
        end
        out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
      end
    end
  end

  initial begin
    int            send_by_phase [BATCHES];
    int            stall_by_phase [BATCHES];
    directed_row_t row;
    lookup_req_t   it;
    rate_result_t  no_result;
    logic [X_W-1:0] x_cursor;
    logic [X_W-1:0] step;
    logic [31:0]   cfg_value;
    int unsigned   top;

    send_by_phase  = '{0, 61, 0, 25};
    stall_by_phase = '{0, 0, 61, 25};
    no_result      = '0;

    // empty table, in both modes
    add_item(REQ_QUERY, '0, '0, 24'h000000, 1, '0, ST_NO_BREAKS, 1'b0);
    add_item(REQ_QUERY, 24'hFFFFFF, 32'hFFFF_FFFF, 24'hFFFFFF, 1, '0, ST_NO_BREAKS, 1'b0);
    add_cfg(REG_RATE_MODE, 32'(MODE_CONST));
    add_cfg(REG_CONST_RATE, 32'hFFFF_FFFF);
    add_item(REQ_QUERY, '0, '0, 24'h001234, 1, 32'hFFFF_FFFF, ST_QUERY_OK, 1'b0);
    add_cfg(REG_CONST_RATE, 32'h0);
    add_item(REQ_QUERY, '0, '0, 24'hFFFFFF, 1, '0, ST_QUERY_OK, 1'b0);
    add_cfg(REG_RATE_MODE, 32'(MODE_TABLE));
    // single breakpoint, then rising, falling and rising segments
    add_item(REQ_LOAD, 24'h000000, 32'h0, '0, 1, '0, ST_LOAD_OK, 1'b0);
    add_item(REQ_QUERY, '0, '0, 24'h000000, 0, '0, '0, 1'b0);
    add_item(REQ_QUERY, '0, '0, 24'hFFFFFF, 1, '0, ST_QUERY_OK, 1'b1);
    add_item(REQ_LOAD, 24'h010000, 32'hFFFF_FFFF, '0, 1, '0, ST_LOAD_OK, 1'b0);
    add_item(REQ_LOAD, 24'h020000, 32'h0, '0, 1, '0, ST_LOAD_OK, 1'b0);
    add_item(REQ_LOAD, 24'h030000, 32'h8000_0000, '0, 1, '0, ST_LOAD_OK, 1'b0);
    add_cfg(REG_GRID_INTERVAL, 32'h100);
    add_cfg(REG_GRID_POINTS, 32'hFFFF);
    add_item(REQ_QUERY, '0, '0, 24'h008001, 0, '0, '0, 1'b0);
    add_item(REQ_QUERY, '0, '0, 24'h017FFF, 0, '0, '0, 1'b0);
    add_item(REQ_QUERY, '0, '0, 24'h010000, 0, '0, '0, 1'b0);
    // exactly on the last breakpoint
    add_item(REQ_QUERY, '0, '0, 24'h030000, 1, 32'h8000_0000, ST_QUERY_OK, 1'b0);
    add_item(REQ_QUERY, '0, '0, 24'hFFFFFF, 0, '0, '0, 1'b0);
    add_cfg(REG_GRID_INTERVAL, 32'hFF_FFFF);
    add_cfg(REG_GRID_POINTS, 32'd2);
    add_item(REQ_QUERY, '0, '0, 24'hFFFFFF, 1, 32'h8000_0000, ST_QUERY_OK, 1'b0);
    add_item(REQ_QUERY, '0, '0, 24'hFFFFFE, 1, '0, ST_QUERY_OK, 1'b0);
    // zero grid interval saturates the index
    add_cfg(REG_GRID_INTERVAL, 32'h0);
    add_item(REQ_QUERY, '0, '0, 24'h000005, 1, '0, ST_QUERY_OK, 1'b1);
    // zero grid points: the index limit is zero
    add_cfg(REG_GRID_INTERVAL, 32'h4000);
    add_cfg(REG_GRID_POINTS, 32'd0);
    add_item(REQ_QUERY, '0, '0, 24'h008000, 1, '0, ST_QUERY_OK, 1'b1);
    // a breakpoint out of order, then a query at or past its x that returns its y
    add_cfg(REG_GRID_POINTS, 32'd20);
    add_item(REQ_LOAD, 24'h018000, 32'h1234_5678, '0, 1, '0, ST_LOAD_OK, 1'b0);
    add_item(REQ_QUERY, '0, '0, 24'h01C000, 0, '0, '0, 1'b0);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.is_cfg) begin
        drain_results();
        write_reg(row.reg_sel, row.reg_value);
      end else begin
        send_item(row.item, row.typed, row.typed_result);
      end
    end

    // random part: mostly ascending loads and queries around the loaded range,
    // a few out-of-order loads; the table fills and later loads are dropped
    x_cursor = 24'h030000;
    for (int phase = 0; phase < BATCHES; phase++) begin
      for (int batch = 0; batch < BATCHES; batch++) begin
        drain_results();
        send_idle_pct = 0;
        stall_pct     = 0;
        write_reg(REG_RATE_MODE,
                  32'(($urandom_range(4) == 0) ? MODE_CONST : MODE_TABLE));
        case ($urandom_range(3))
          0:       cfg_value = 32'h0;
          1:       cfg_value = 32'hFFFF_FFFF;
          default: cfg_value = $urandom();
        endcase
        write_reg(REG_CONST_RATE, cfg_value);
        case ($urandom_range(4))
          0:       cfg_value = 32'h1;
          1:       cfg_value = 32'hFF_FFFF;
          2:       cfg_value = $urandom_range(16, 1);
          3:       cfg_value = $urandom_range(32'h400, 1);
          default: cfg_value = $urandom_range(32'hFF_FFFF, 1);
        endcase
        write_reg(REG_GRID_INTERVAL, cfg_value);
        case ($urandom_range(3))
          0:       cfg_value = 32'd2;
          1:       cfg_value = 32'hFFFF;
          2:       cfg_value = $urandom_range(300, 2);
          default: cfg_value = $urandom_range(32'hFFFF, 2);
        endcase
        write_reg(REG_GRID_POINTS, cfg_value);
        send_idle_pct = send_by_phase[phase];
        stall_pct     = stall_by_phase[phase];

        for (int n = 0; n < BATCH_ITEMS; n++) begin
          it.bx = X_W'($urandom_range(32'hFF_FFFF));
          it.by = $urandom();
          it.qv = X_W'($urandom_range(32'hFF_FFFF));
          if ($urandom_range(99) < 50) begin
            it.req = REQ_LOAD;
            if ($urandom_range(15) != 0) begin
              step = ($urandom_range(15) == 0) ? X_W'($urandom_range(32'h80000, 1))
                                                : X_W'($urandom_range(32'h3000, 1));
              if (x_cursor > 24'hFFFFFF - step) x_cursor = 24'hFFFFFF;
              else x_cursor = x_cursor + step;
              it.bx = x_cursor;
              case ($urandom_range(7))
                0:       it.by = 32'h0;
                1:       it.by = 32'hFFFF_FFFF;
                default: it.by = $urandom();
              endcase
            end
          end else begin
            it.req = REQ_QUERY;
            case ($urandom_range(3))
              0: ;
              1: it.qv = bp_x_mem[$urandom_range(bp_count - 1)];
              default: begin
                top = x_cursor + x_cursor / 8 + 16;
                if (top > 32'hFF_FFFF) top = 32'hFF_FFFF;
                it.qv = X_W'($urandom_range(top));
              end
            endcase
          end
          send_item(it, 1'b0, no_result);
        end
      end
    end

    drain_results();
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: piecewise_linear_rate_lookup.f
hdl/plr_pkg.sv
hdl/plr_divider.sv
hdl/plr_table.sv
hdl/piecewise_linear_rate_lookup.sv
hdl/plr_checker.sv
tb/sv/tb_piecewise_linear_rate_lookup.sv
